// File: hw/rtl/sh_pkg.sv
`default_nettype none
package sh_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned TAIL_W = 3;
	localparam int unsigned BLK_W = 5;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned RND_W = 3;

	// rounds per compression and per finalization
	localparam int unsigned C_ROUNDS = 2;
	localparam int unsigned D_ROUNDS = 4;

	localparam logic [WORD_W-1:0] LANE_C0 = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] LANE_C1 = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] LANE_C2 = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] LANE_C3 = 64'h7465646279746573;
	localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

	// register select is paddr[3]; the low bits address bytes within the word
	localparam logic REG_KEY_LOW = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] v0;
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] v2;
		logic [WORD_W-1:0] v3;
	} sh_lanes_t;

	// request from the input register to the round engine
	typedef struct packed {
		logic              start;
		logic              last;
		logic [TAIL_W-1:0] tail;
		logic [WORD_W-1:0] word;
	} sh_req_t;

	// engine status back to the top level
	typedef struct packed {
		logic idle;
		logic done;
	} sh_stat_t;

	function automatic sh_lanes_t sh_round(input sh_lanes_t v);
		logic [WORD_W-1:0] a, b, c, d;
		sh_lanes_t r;
		a = v.v0;
		b = v.v1;
		c = v.v2;
		d = v.v3;
		a = a + b;
		b = {b[50:0], b[63:51]};
		b = b ^ a;
		a = {a[31:0], a[63:32]};
		c = c + d;
		d = {d[47:0], d[63:48]};
		d = d ^ c;
		a = a + d;
		d = {d[42:0], d[63:43]};
		d = d ^ a;
		c = c + b;
		b = {b[46:0], b[63:47]};
		b = b ^ c;
		c = {c[31:0], c[63:32]};
		r.v0 = a;
		r.v1 = b;
		r.v2 = c;
		r.v3 = d;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sh_ifs.sv
`default_nettype none
interface sh_in_if import sh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] message_word;
	logic [TAIL_W-1:0] tail_bytes;
	logic              last;

	modport source(output valid, output message_word, output tail_bytes, output last,
		input ready);
	modport sink(input valid, input message_word, input tail_bytes, input last,
		output ready);
endinterface

interface sh_out_if import sh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash;

	modport source(output valid, output hash, input ready);
	modport sink(input valid, input hash, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sh_core.sv
`default_nettype none
module sh_core import sh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sh_req_t           req,
	input  wire logic [WORD_W-1:0] key_low,
	input  wire logic [WORD_W-1:0] key_high,
	input  wire logic              out_free,
	output sh_stat_t               stat,
	output logic [WORD_W-1:0]      hash
);

	localparam logic [RND_W-1:0] RND_BLOCK = RND_W'(C_ROUNDS - 1);
	localparam logic [RND_W-1:0] RND_LAST = RND_W'(C_ROUNDS + D_ROUNDS - 1);
	localparam logic [RND_W-1:0] RND_ONE = RND_W'(1);

	sh_lanes_t         v_q;
	logic [RND_W-1:0]  rnd_q;
	logic [WORD_W-1:0] m_q;
	logic              last_q;
	logic              in_msg_q;
	logic [BLK_W-1:0]  blk_q;

	sh_lanes_t         base, prep, rnd_in, rnd_out, post;
	logic [BLK_W-1:0]  blk_eff;
	logic [WORD_W-1:0] m_in;
	logic              busy, final_rnd, stall, post_pt;

	always_comb begin
		blk_eff = in_msg_q ? blk_q : '0;
		if (in_msg_q) begin
			base = v_q;
		end else begin
			base.v0 = key_low ^ LANE_C0;
			base.v1 = key_high ^ LANE_C1;
			base.v2 = key_low ^ LANE_C2;
			base.v3 = key_high ^ LANE_C3;
		end

		// final block: tail bytes below, length byte on top
		if (req.last) begin
			m_in = '0;
			for (int i = 0; i < 7; i++) begin
				if (TAIL_W'(i) < req.tail) begin
					m_in[8*i +: 8] = req.word[8*i +: 8];
				end
			end
			m_in[63:56] = {blk_eff, req.tail};
		end else begin
			m_in = req.word;
		end

		prep = base;
		prep.v3 = base.v3 ^ m_in;
		rnd_in = req.start ? prep : v_q;
		rnd_out = sh_round(rnd_in);

		busy = (rnd_q != '0);
		final_rnd = busy && last_q && (rnd_q == RND_ONE);
		stall = final_rnd && !out_free;
		// end of compression: close the block into v0, flag finalization in v2
		post_pt = busy && (rnd_q == (last_q ? RND_W'(D_ROUNDS + C_ROUNDS - 1) : RND_BLOCK));
		post = rnd_out;
		if (post_pt) begin
			post.v0 = rnd_out.v0 ^ m_q;
			if (last_q) begin
				post.v2 = rnd_out.v2 ^ FINAL_XOR;
			end
		end

		stat.idle = !busy;
		stat.done = final_rnd && out_free;
		hash = rnd_out.v0 ^ rnd_out.v1 ^ rnd_out.v2 ^ rnd_out.v3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			in_msg_q <= 1'b0;
			blk_q <= '0;
		end else if (req.start) begin
			rnd_q <= req.last ? RND_LAST : RND_BLOCK;
			in_msg_q <= !req.last;
			blk_q <= req.last ? '0 : blk_eff + BLK_W'(1);
		end else if (busy && !stall) begin
			rnd_q <= rnd_q - RND_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= rnd_out;
			m_q <= m_in;
			last_q <= req.last;
		end else if (busy && !stall) begin
			v_q <= post;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/siphash_2_4_keyed_hash.sv
`default_nettype none
// SipHash-2-4 engine. Load the 128-bit key through the APB port (key_low at
// 0x0, key_high at 0x8, 64-bit data), then stream a message as words on msg:
// every word with last low is one full 8-byte little-endian block, the word
// with last high holds the 0 to 7 tail bytes (tail_bytes says how many) and
// closes the message; one hash word then appears on res. A single SipRound
// unit does one round per cycle unless stalled, so a full block takes 2
// rounds and the closing word 6 (2 compression plus 4 finalization rounds);
// a new word enters the engine only once the last one's rounds are done. The
// hash lands in the output register after the closing word's rounds, later
// when the engine is still busy with an earlier word. An input register
// and an output register decouple both sides: msg keeps taking words while a
// finished hash waits, and only the last finalization round waits on res.
// The key is sampled when the first word of a message enters the engine.
module siphash_2_4_keyed_hash import sh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sh_in_if.sink                  msg,
	sh_out_if.source               res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0]      prdata,
	output logic                   pready
);

	// key registers
	logic [WORD_W-1:0] key_low_q, key_high_q;
	logic              cfg_wr;

	// input register
	logic              pend_v_q;
	logic [WORD_W-1:0] pend_word_q;
	logic [TAIL_W-1:0] pend_tail_q;
	logic              pend_last_q;

	// output register
	logic              out_v_q;
	logic [WORD_W-1:0] hash_q;

	sh_req_t           req;
	sh_stat_t          stat;
	logic [WORD_W-1:0] core_hash;
	logic              msg_acc, res_acc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3])
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_KEY_LOW:  key_low_q <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default:      ;
			endcase
		end
	end

	// a waiting word enters the engine as soon as the round unit is free
	assign req.start = pend_v_q && stat.idle;
	assign req.last = pend_last_q;
	assign req.tail = pend_tail_q;
	assign req.word = pend_word_q;

	assign msg.ready = !pend_v_q || req.start;
	assign msg_acc = msg.valid && msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (msg_acc) begin
			pend_v_q <= 1'b1;
		end else if (req.start) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_acc) begin
			pend_word_q <= msg.message_word;
			pend_tail_q <= msg.tail_bytes;
			pend_last_q <= msg.last;
		end
	end

	sh_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.key_low  (key_low_q),
		.key_high (key_high_q),
		.out_free (!out_v_q || res.ready),
		.stat     (stat),
		.hash     (core_hash)
	);

	assign res.valid = out_v_q;
	assign res.hash = hash_q;
	assign res_acc = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (stat.done) begin
			out_v_q <= 1'b1;
		end else if (res_acc) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			hash_q <= core_hash;
		end
	end

	// a finished hash never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (!out_v_q || res.ready))
		else $error("hash produced while output register is full");

	// a word taken while the engine is busy is held, not dropped
	a_pend_held: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !stat.idle) |=> pend_v_q)
		else $error("pending word lost while engine busy");

	// a hash follows only a closing word that entered the engine
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(!stat.idle))
		else $error("hash without an active message");

endmodule
`default_nettype wire

// File: sim/siphash_2_4_keyed_hash_chk.sv
`timescale 1ns / 100ps
module siphash_2_4_keyed_hash_chk import sh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sh_in_if                       msg,
	sh_out_if                      res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output int unsigned            hash_errors,
	output int unsigned            hashes_owed
);

	typedef logic [WORD_W-1:0] lane_t;

	localparam int unsigned REPORT_MAX = 10;

	// shadow of the engine
	lane_t            key_lo, key_hi;
	lane_t            v0, v1, v2, v3;
	logic [BLK_W-1:0] blocks_seen;
	logic             msg_open;
	lane_t            hashes_due[$];
	int unsigned      err_n;

	function automatic lane_t rotl(input lane_t x, input int unsigned s);
		return (x << s) | (x >> (WORD_W - s));
	endfunction

	task automatic mix_lanes();
		v0 = v0 + v1; v1 = rotl(v1, 13); v1 = v1 ^ v0; v0 = rotl(v0, 32);
		v2 = v2 + v3; v3 = rotl(v3, 16); v3 = v3 ^ v2;
		v0 = v0 + v3; v3 = rotl(v3, 21); v3 = v3 ^ v0;
		v2 = v2 + v1; v1 = rotl(v1, 17); v1 = v1 ^ v2; v2 = rotl(v2, 32);
	endtask

	task automatic compress_block(input lane_t m);
		v3 = v3 ^ m;
		mix_lanes();
		mix_lanes();
		v0 = v0 ^ m;
	endtask

	// one accepted word; a closing word queues the hash it yields
	task automatic absorb_word(input lane_t w, input logic [TAIL_W-1:0] n, input logic fin);
		lane_t      m;
		logic [7:0] len_byte;
		if (!msg_open) begin
			v0 = key_lo ^ LANE_C0;
			v1 = key_hi ^ LANE_C1;
			v2 = key_lo ^ LANE_C2;
			v3 = key_hi ^ LANE_C3;
			blocks_seen = '0;
			msg_open = 1'b1;
		end
		if (!fin) begin
			compress_block(w);
			blocks_seen = blocks_seen + 1'b1;
		end else begin
			len_byte = {blocks_seen, 3'b000} + 8'(n);
			m = {len_byte, 56'd0} | (w & ((64'd1 << (8 * int'(n))) - 64'd1));
			compress_block(m);
			v2 = v2 ^ FINAL_XOR;
			repeat (D_ROUNDS) mix_lanes();
			hashes_due.push_back(v0 ^ v1 ^ v2 ^ v3);
			blocks_seen = '0;
			msg_open = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			v0 = '0; v1 = '0; v2 = '0; v3 = '0;
			blocks_seen = '0;
			msg_open = 1'b0;
			hashes_due.delete();
			err_n = 0;
			hash_errors <= 0;
			hashes_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_KEY_HIGH) key_hi = pwdata;
				else key_lo = pwdata;
			end
			if (msg.valid && msg.ready)
				absorb_word(msg.message_word, msg.tail_bytes, msg.last);
			if (res.valid && res.ready) begin
				if (hashes_due.size() == 0) begin
					if (err_n < REPORT_MAX)
						$display("%0t: hash %016h with no message closed", $realtime, res.hash);
					err_n++;
				end else begin
					if (res.hash !== hashes_due[0]) begin
						if (err_n < REPORT_MAX)
							$display("%0t: hash mismatch: expected %016h got %016h",
								$realtime, hashes_due[0], res.hash);
						err_n++;
					end
					void'(hashes_due.pop_front());
				end
			end
			hash_errors <= err_n;
			hashes_owed <= hashes_due.size();
		end
	end

endmodule

// File: sim/siphash_2_4_keyed_hash_tb.sv
`timescale 1ns / 100ps
module siphash_2_4_keyed_hash_tb;
	import sh_pkg::*;

	typedef logic [WORD_W-1:0] lane_t;

	// how a message's bytes are filled
	typedef enum int {PAT_RANDOM, PAT_COUNT, PAT_ZEROS, PAT_ONES} fill_e;

	localparam int unsigned STALL_LIMIT = 4000; // cycles with no handshake at all
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned PHASE_WORDS = 190;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [WORD_W-1:0] pwdata, prdata;
	logic              pready;

	int unsigned hash_errors, hashes_owed;
	int unsigned src_idle_pct = 0;   // chance per cycle that the sender holds off
	int unsigned sink_stall_pct = 0; // chance per cycle that the receiver stalls
	int unsigned words_sent = 0;
	int unsigned quiet_cycles = 0;

	sh_in_if  msg();
	sh_out_if res();

	siphash_2_4_keyed_hash dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	siphash_2_4_keyed_hash_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg         (msg),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.hash_errors (hash_errors),
		.hashes_owed (hashes_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: one ready decision per cycle, held low through reset
	always @(posedge clk) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// watchdog: any accepted word or hash, or register write, restarts the count
	always @(posedge clk) begin
		if ((msg.valid && msg.ready) || (res.valid && res.ready) ||
			(psel && penable && pwrite && pready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic lane_t fill_word(input fill_e pat, input int unsigned base);
		lane_t w;
		case (pat)
			PAT_COUNT: begin
				for (int k = 0; k < 8; k++) w[8*k +: 8] = 8'(base + k);
			end
			PAT_ZEROS: w = '0;
			PAT_ONES:  w = '1;
			default:   w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// Presents one word and returns at the edge that takes it. Entered and left
	// right after a rising edge, so valid is written once per step at most.
	task automatic put_word(input lane_t w, input logic [TAIL_W-1:0] n, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			msg.valid <= 1'b0;
			@(posedge clk);
		end
		msg.valid        <= 1'b1;
		msg.message_word <= w;
		msg.tail_bytes   <= n;
		msg.last         <= fin;
		@(posedge clk);
		while (!msg.ready) @(posedge clk);
		words_sent++;
	endtask

	// full blocks carry a random tail count, which the engine must ignore
	task automatic send_message(input int unsigned nblk, input int unsigned tail,
		input fill_e pat);
		lane_t w;
		for (int b = 0; b < nblk; b++)
			put_word(fill_word(pat, 8 * b), 3'($urandom_range(7)), 1'b0);
		w = fill_word(pat, 8 * nblk);
		// bytes above the tail are junk that must not reach the hash
		if (pat == PAT_COUNT)
			for (int k = tail; k < 8; k++) w[8*k +: 8] = 8'($urandom);
		put_word(w, 3'(tail), 1'b1);
	endtask

	// drop valid, wait for every owed hash, then let the engine settle
	task automatic drain();
		msg.valid <= 1'b0;
		@(posedge clk);
		while (hashes_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// two-phase write; one idle cycle after so writes never abut
	task automatic write_key(input logic sel, input lane_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Random messages: mostly short, a fifth with no full block, and a few of 31
	// to 40 blocks, so the block count can wrap and the length byte roll over.
	task automatic random_phase(input int unsigned n_words);
		int unsigned base_count;
		int unsigned r;
		int unsigned nblk;
		fill_e       pat;
		base_count = words_sent;
		while (words_sent - base_count < n_words) begin
			r = $urandom_range(99);
			if (r < 5) nblk = $urandom_range(40, 31);
			else if (r < 25) nblk = 0;
			else nblk = $urandom_range(6, 1);
			r = $urandom_range(99);
			pat = (r < 85) ? PAT_RANDOM : fill_e'($urandom_range(3, 1));
			send_message(nblk, $urandom_range(7), pat);
		end
	endtask

	initial begin
		msg.valid        <= 1'b0;
		msg.message_word <= '0;
		msg.tail_bytes   <= '0;
		msg.last         <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message under the all-zero key left by reset
		send_message(0, 0, PAT_RANDOM);
		drain();

		// the usual test-vector key; counting-byte messages hit the tail
		// and block boundaries
		write_key(REG_KEY_LOW, 64'h0706050403020100);
		write_key(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
		send_message(0, 0, PAT_COUNT);
		send_message(0, 7, PAT_COUNT);
		send_message(1, 0, PAT_COUNT);
		send_message(1, 7, PAT_COUNT);
		send_message(2, 3, PAT_COUNT);
		send_message(1, 7, PAT_ZEROS);
		send_message(1, 7, PAT_ONES);
		send_message(0, 7, PAT_ONES);
		send_message(0, 1, PAT_ZEROS);
		// all-ones word with tail zero: every byte must drop out
		send_message(0, 0, PAT_ONES);

		// no idling on either side
		random_phase(PHASE_WORDS);
		drain();

		// all-ones key, sender mostly idle
		write_key(REG_KEY_LOW, '1);
		write_key(REG_KEY_HIGH, '1);
		src_idle_pct = 87;
		random_phase(PHASE_WORDS);
		drain();

		// random key, receiver mostly stalled
		write_key(REG_KEY_LOW, {$urandom, $urandom});
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		src_idle_pct = 0;
		sink_stall_pct = 87;
		random_phase(PHASE_WORDS);
		drain();

		// mixed key halves, both sides idling now and then
		write_key(REG_KEY_LOW, '0);
		write_key(REG_KEY_HIGH, '1);
		src_idle_pct = 34;
		sink_stall_pct = 34;
		random_phase(PHASE_WORDS);
		drain();

		if (hash_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: siphash_2_4_keyed_hash.f
hw/rtl/sh_pkg.sv
hw/rtl/sh_ifs.sv
hw/rtl/sh_core.sv
hw/rtl/siphash_2_4_keyed_hash.sv
sim/siphash_2_4_keyed_hash_chk.sv
sim/siphash_2_4_keyed_hash_tb.sv
